// ===== rtl/core/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared operation codes, status codes, order codes and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int unsigned DefValueWidth = 32;
	localparam int unsigned FieldWidth    = 32;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_RED  = 3'd4,
		OP_CMP  = 3'd5,
		OP_INT  = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_ZERO = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ORD_LT = 2'd0,
		ORD_EQ = 2'd1,
		ORD_GT = 2'd2
	} order_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_GCD,
		S_QUOT,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Sequencing: multiply kinds step through S_MUL1, S_MUL2 and S_MUL3 to S_DONE;
// reduce and integer test run one Euclid remainder at a time in S_GCD (one
// load step and W bit steps each), and reduce then adds two quotient divisions
// in S_QUOT. A zero denominator or the unused kind goes straight to S_DONE.
// One word is in work at a time; s_tready is low until the result is taken.
// The shared unit is a W-step restoring divider plus one WxW multiplier.
// Reset (arst_n low, asynchronous) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Cross-multiplied fraction arithmetic, gcd reduction, compare, integer test.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = DefValueWidth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
	input  logic [127:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// res_num[31:0], res_den[63:32], order[65:64], is_integer[66], status[68:67], zero
	output logic [71:0]  m_tdata
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned CW = $clog2(W + 1);

	state_t state_q, state_d;

	// Captured operands: numerators as sign and magnitude, denominators as given.
	op_t          kind_q;
	logic         an_neg_q, bn_neg_q;
	logic [W-1:0] an_mag_q, ad_q, bn_mag_q, bd_q;

	// Multiplier operands and products.
	logic [W-1:0]   mx, my;
	logic [2*W-1:0] prod;
	logic [2*W-1:0] p0_q, p1_q, p2_q;

	// Divider registers: remainder, quotient, divisor, dividend, bit counter.
	logic [W-1:0]   rem_q, quo_q, dvs_q, dvd_q;
	logic [W-1:0]   gp_q, gq_q;
	logic [CW-1:0]  cnt_q;
	logic           pass_q;
	logic [W:0]     trial;
	logic [W-1:0]   rem_sh;

	// Result register.
	logic [W-1:0]   rnum_q, rden_q;
	logic [1:0]     order_q, status_q;
	logic           isint_q;
	logic           ovalid_q;

	// Input field split.
	logic [W-1:0]   in_an, in_ad, in_bn, in_bd;
	assign in_an = s_tdata[W-1:0];
	assign in_ad = s_tdata[32+W-1:32];
	assign in_bn = s_tdata[64+W-1:64];
	assign in_bd = s_tdata[96+W-1:96];

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	assign s_tready = (state_q == S_IDLE) && !ovalid_q;

	// Shared multiplier; operand pair chosen by step.
	always_comb begin
		mx = an_mag_q;
		my = bd_q;
		case (state_q)
			S_MUL1: begin
				mx = an_mag_q;
				my = (kind_q == OP_MUL) ? bn_mag_q : bd_q;
			end
			S_MUL2: begin
				mx = ad_q;
				my = bn_mag_q;
			end
			S_MUL3: begin
				mx = ad_q;
				my = (kind_q == OP_DIV) ? bn_mag_q : bd_q;
			end
			default: begin
				mx = an_mag_q;
				my = bd_q;
			end
		endcase
	end
	assign prod = {{W{1'b0}}, mx} * {{W{1'b0}}, my};

	// One restoring division step.
	assign rem_sh = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial  = {rem_q, dvd_q[W-1]} - {1'b0, dvs_q};

	// Sign-magnitude combine of the two products for the final result.
	logic           sa, sb, rneg;
	logic [2*W:0]   rmag;
	logic           fits;
	logic [W-1:0]   rwrap;
	logic           cmp_gt, cmp_eq;
	always_comb begin
		sa = an_neg_q;
		sb = (kind_q == OP_SUB) ? ~bn_neg_q : bn_neg_q;
		if (p0_q == '0) sa = 1'b0;
		if (p1_q == '0) sb = 1'b0;
		rneg = sa;
		rmag = {1'b0, p0_q};
		case (kind_q)
			OP_ADD, OP_SUB: begin
				if (sa == sb) begin
					rneg = sa;
					rmag = {1'b0, p0_q} + {1'b0, p1_q};
				end else if (p0_q >= p1_q) begin
					rneg = sa;
					rmag = {1'b0, p0_q - p1_q};
				end else begin
					rneg = sb;
					rmag = {1'b0, p1_q - p0_q};
				end
			end
			OP_MUL: rneg = an_neg_q ^ bn_neg_q;
			OP_DIV: rneg = an_neg_q ^ bn_neg_q;
			default: rneg = sa;
		endcase
		if (rmag == '0) rneg = 1'b0;
		fits = rneg ? (rmag <= ({{(W+1){1'b0}}, 1'b1} << (W-1)))
		            : (rmag <  ({{(W+1){1'b0}}, 1'b1} << (W-1)));
		rwrap = rneg ? (~rmag[W-1:0] + 1'b1) : rmag[W-1:0];
		// Compare a_num*b_den (p0) with b_num*a_den (p1).
		cmp_eq = (an_neg_q == bn_neg_q || (p0_q == '0 && p1_q == '0)) && p0_q == p1_q;
		if (p0_q == '0 && p1_q == '0)
			cmp_gt = 1'b0;
		else if ((an_neg_q && p0_q != '0) != (bn_neg_q && p1_q != '0))
			cmp_gt = !(an_neg_q && p0_q != '0);
		else if (an_neg_q && p0_q != '0)
			cmp_gt = p0_q < p1_q;
		else
			cmp_gt = p0_q > p1_q;
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					if (in_ad == '0) state_d = S_DONE;
					else if (s_tuser == OP_RED || s_tuser == OP_INT) state_d = S_GCD;
					else if (s_tuser == OP_NONE) state_d = S_DONE;
					else if (in_bd == '0) state_d = S_DONE;
					else if (s_tuser == OP_DIV && in_bn == '0) state_d = S_DONE;
					else state_d = S_MUL1;
				end
			end
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_DONE;
			S_GCD: begin
				if (gq_q == '0) state_d = (kind_q == OP_RED) ? S_QUOT : S_DONE;
				else if (cnt_q == CW'(W)) state_d = S_GCD;
			end
			S_QUOT: begin
				if (cnt_q == CW'(W) && pass_q) state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				kind_q   <= op_t'(s_tuser);
				an_neg_q <= in_an[W-1];
				an_mag_q <= mag_of(in_an);
				bn_neg_q <= in_bn[W-1];
				bn_mag_q <= mag_of(in_bn);
				ad_q     <= in_ad;
				bd_q     <= in_bd;
				gp_q     <= mag_of(in_an);
				gq_q     <= in_ad;
				cnt_q    <= '0;
				pass_q   <= 1'b0;
				rem_q    <= '0;
				dvd_q    <= mag_of(in_an);
				dvs_q    <= in_ad;
				p0_q     <= '0;
				p1_q     <= '0;
				p2_q     <= '0;
			end
			S_MUL1: p0_q <= prod;
			S_MUL2: p1_q <= prod;
			S_MUL3: begin
				p2_q <= prod;
				if (kind_q == OP_DIV || kind_q == OP_MUL) p1_q <= '0;
			end
			S_GCD: begin
				// gp mod gq, one bit per cycle; gcd(0,q)=q handled by swap.
				if (gq_q == '0) begin
					rem_q  <= '0;
					dvd_q  <= an_mag_q;
					dvs_q  <= gp_q;
					cnt_q  <= '0;
					pass_q <= 1'b0;
				end else if (cnt_q == '0) begin
					rem_q <= '0;
					dvd_q <= gp_q;
					dvs_q <= gq_q;
					cnt_q <= cnt_q + 1'b1;
				end else if (cnt_q == CW'(W)) begin
					gp_q  <= gq_q;
					gq_q  <= trial[W] ? rem_sh : trial[W-1:0];
					cnt_q <= '0;
				end else begin
					rem_q <= trial[W] ? rem_sh : trial[W-1:0];
					dvd_q <= {dvd_q[W-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_QUOT: begin
				if (cnt_q == CW'(W)) begin
					// First pass gave |a_num|/g; run again for a_den/g.
					if (!pass_q) begin
						p0_q   <= {{W{1'b0}}, quo_q};
						rem_q  <= '0;
						dvd_q  <= ad_q;
						cnt_q  <= '0;
						pass_q <= 1'b1;
					end
				end else begin
					rem_q <= trial[W] ? rem_sh : trial[W-1:0];
					dvd_q <= {dvd_q[W-2:0], 1'b0};
					quo_q <= {quo_q[W-2:0], ~trial[W]};
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// The last quotient bit lands at count W-1; the final value is quo_q at W.
	// Result formation and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_DONE) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE) begin
			rnum_q   <= '0;
			rden_q   <= '0;
			order_q  <= ORD_EQ;
			isint_q  <= 1'b0;
			status_q <= ST_OK;
			if (ad_q == '0 || ((kind_q <= OP_DIV || kind_q == OP_CMP) && bd_q == '0)
			    || (kind_q == OP_DIV && bn_mag_q == '0)) begin
				if (kind_q != OP_NONE) status_q <= ST_ZERO;
			end else begin
				case (kind_q)
					OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
						rnum_q <= rwrap;
						rden_q <= p2_q[W-1:0];
						if (!fits || p2_q[2*W-1:W] != '0) status_q <= ST_OVF;
					end
					OP_RED: begin
						rnum_q <= an_neg_q ? (~p0_q[W-1:0] + 1'b1) : p0_q[W-1:0];
						rden_q <= quo_q;
					end
					OP_CMP: order_q <= cmp_eq ? ORD_EQ : (cmp_gt ? ORD_GT : ORD_LT);
					OP_INT: isint_q <= (gp_q == ad_q);
					default: begin
					end
				endcase
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {3'b000, status_q, isint_q, order_q,
	                   FieldWidth'(rden_q), FieldWidth'($signed(rnum_q))};

endmodule

// ===== rtl/core/rau_checker.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module rau_checker
	import rau_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata
);

	// A word is never accepted while a result waits.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken while result pending");

	// Acceptance takes the unit busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready) else $error("unit not busy");

	// A held result stays stable.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed under stall");

	// Status code is never the unused value.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[68:67] != 2'd3)) else $error("bad status");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
